>>> src/mcfp_pkg.sv
`default_nettype none

package mcfp_pkg;

  // Fixed-point format of every input and register
  localparam int FRAC_BITS = 16;

  // Field widths
  localparam int IN_W      = 32;
  localparam int REG_W     = 31;
  localparam int CFG_IDX_W = 3;
  localparam int FRAME_W   = 64;

  // Code widths of the frame fields
  localparam int POS_BITS = 16;
  localparam int GEN_BITS = 12;
  localparam int CODE_W   = POS_BITS;

  // Datapath widths: bounds, span (divisor) and dividend
  localparam int LW = IN_W + 2;
  localparam int DW = IN_W + 1;
  localparam int NW = DW + CODE_W;

  // Lanes, one per quantized value
  localparam int LANES  = 5;
  localparam int LN_POS = 0;
  localparam int LN_VEL = 1;
  localparam int LN_KP  = 2;
  localparam int LN_KD  = 3;
  localparam int LN_TAU = 4;

  // Fixed gain ranges
  localparam int STIFF_INT = 500;
  localparam int DAMP_INT  = 5;
  localparam logic [DW-1:0] STIFF_SPAN = DW'(STIFF_INT) << FRAC_BITS;
  localparam logic [DW-1:0] DAMP_SPAN  = DW'(DAMP_INT) << FRAC_BITS;

  // Register reset values
  localparam logic [REG_W-1:0] POS_RANGE_RST = REG_W'(819200);
  localparam logic [REG_W-1:0] VEL_RANGE_RST = REG_W'(1966080);
  localparam logic [REG_W-1:0] TRQ_RANGE_RST = REG_W'(655360);
  localparam logic [REG_W-1:0] TRQ_LIMIT_RST = REG_W'(196608);

  // Pipeline stage numbering
  localparam int ST_IN  = 0;
  localparam int ST_CLP = 1;
  localparam int ST_NUM = 2;
  localparam int ST_MUL = 3;
  localparam int NSTG   = ST_MUL + CODE_W + 1;
  localparam int LAST   = NSTG - 1;

  typedef logic [IN_W-1:0]    val_t;
  typedef logic [REG_W-1:0]   reg_t;
  typedef logic [CODE_W-1:0]  code_t;
  typedef logic [LW-1:0]      bound_t;
  typedef logic [DW-1:0]      span_t;
  typedef logic [NW-1:0]      rem_t;
  typedef logic [FRAME_W-1:0] frame_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POS_RANGE = CFG_IDX_W'(0),
    REG_VEL_RANGE = CFG_IDX_W'(1),
    REG_TRQ_RANGE = CFG_IDX_W'(2),
    REG_TRQ_LIMIT = CFG_IDX_W'(3)
  } cfg_reg_t;

  function automatic int lane_bits(input int lane);
    return (lane == LN_POS) ? POS_BITS : GEN_BITS;
  endfunction

  function automatic code_t lane_full(input int lane);
    return code_t'((1 << lane_bits(lane)) - 1);
  endfunction

endpackage

`default_nettype wire

>>> src/mcfp_if.sv
`default_nettype none

// Motor command channel
interface mcfp_cmd_if import mcfp_pkg::*; ();
  logic valid;
  logic ready;
  val_t position_target;
  val_t velocity_target;
  val_t stiffness_gain;
  val_t damping_gain;
  val_t torque_feedforward;

  modport source (
    output valid, position_target, velocity_target, stiffness_gain,
    output damping_gain, torque_feedforward,
    input  ready
  );
  modport sink (
    input  valid, position_target, velocity_target, stiffness_gain,
    input  damping_gain, torque_feedforward,
    output ready
  );
endinterface

// Packed frame channel
interface mcfp_frame_if import mcfp_pkg::*; ();
  logic   valid;
  logic   ready;
  frame_t command_frame;

  modport source (output valid, command_frame, input ready);
  modport sink   (input valid, command_frame, output ready);
endinterface

// Register write channel
interface mcfp_cfg_if import mcfp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  reg_t                 data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/mit_command_frame_packer.sv
`default_nettype none

// Channel   Dir  Handshake    Payload
// in_ch     in   valid/ready  position_target, velocity_target, stiffness_gain,
//                             damping_gain, torque_feedforward (s32 each)
// out_ch    out  valid/ready  command_frame (64 bit, byte 0 in 63..56)
// cfg_ch    in   valid/ready  index (3 bit), data (31 bit); ready always high
//
// One command per clock while the skid is empty. An accepted command reaches
// out_ch.valid through the input register, clamp, bound check, dividend
// build, one restoring division stage per quotient bit (16), output register.
// Reset restores the default ranges and torque limit and empties the pipe.
// A stalled output fills a one-entry skid; the pipe freezes only when the
// skid is full, so nothing is dropped or repeated.

module mit_command_frame_packer import mcfp_pkg::*; (
  input  wire               clk,
  input  wire               rst_n,
  mcfp_cmd_if.sink          in_ch,
  mcfp_frame_if.source      out_ch,
  mcfp_cfg_if.sink          cfg_ch
);

  // Configuration registers
  reg_t pos_range_r;
  reg_t vel_range_r;
  reg_t trq_range_r;
  reg_t trq_limit_r;

  // Pipeline control
  logic [NSTG-1:0] v_r;
  logic            en;
  logic            push;

  // Output register and skid
  logic   out_v_r;
  frame_t out_frame_r;
  logic   skid_v_r;
  frame_t skid_frame_r;

  // Stage payloads
  val_t   in_vals   [LANES];
  val_t   a_r       [LANES];
  val_t   b_r       [LANES];
  val_t   b_nxt     [LANES];
  span_t  num_r     [LANES];
  span_t  num_nxt   [LANES];
  logic [LANES-1:0] c_lof_r;
  logic [LANES-1:0] c_hif_r;
  logic [LANES-1:0] c_lof_nxt;
  logic [LANES-1:0] c_hif_nxt;
  rem_t   rem_r     [CODE_W+1][LANES];
  code_t  quo_r     [CODE_W+1][LANES];
  logic [LANES-1:0] lof_r [CODE_W+1];
  logic [LANES-1:0] hif_r [CODE_W+1];
  rem_t   div0_nxt  [LANES];
  rem_t   trial_w   [1:CODE_W][LANES];
  rem_t   rem_nxt   [1:CODE_W][LANES];
  code_t  quo_nxt   [1:CODE_W][LANES];
  logic [LANES-1:0] ge_w [1:CODE_W];

  // Range bounds from configuration
  bound_t lo_w [LANES];
  bound_t hi_w [LANES];
  span_t  span_w [LANES];
  bound_t xs_w [LANES];

  // Clamp helpers
  val_t lim_w;
  val_t nlim_w;

  // Result assembly
  code_t  code_w [LANES];
  frame_t frame_nxt;

  // Handshakes
  assign en           = !skid_v_r;
  assign push         = en && v_r[LAST];
  assign in_ch.ready  = en;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid         = out_v_r;
  assign out_ch.command_frame = out_frame_r;

  assign in_vals[LN_POS] = in_ch.position_target;
  assign in_vals[LN_VEL] = in_ch.velocity_target;
  assign in_vals[LN_KP]  = in_ch.stiffness_gain;
  assign in_vals[LN_KD]  = in_ch.damping_gain;
  assign in_vals[LN_TAU] = in_ch.torque_feedforward;

  // Build lane bounds and spans
  always_comb begin
    hi_w[LN_POS] = LW'(pos_range_r);
    hi_w[LN_VEL] = LW'(vel_range_r);
    hi_w[LN_TAU] = LW'(trq_range_r);
    hi_w[LN_KP]  = LW'(STIFF_SPAN);
    hi_w[LN_KD]  = LW'(DAMP_SPAN);
    lo_w[LN_POS] = ~hi_w[LN_POS] + LW'(1);
    lo_w[LN_VEL] = ~hi_w[LN_VEL] + LW'(1);
    lo_w[LN_TAU] = ~hi_w[LN_TAU] + LW'(1);
    lo_w[LN_KP]  = '0;
    lo_w[LN_KD]  = '0;
    for (int l = 0; l < LANES; l++) begin
      span_w[l] = DW'(hi_w[l] - lo_w[l]);
    end
  end

  // Clamp feedforward torque to the symmetric limit
  always_comb begin
    lim_w  = IN_W'(trq_limit_r);
    nlim_w = ~lim_w + IN_W'(1);
    for (int l = 0; l < LANES; l++) begin
      b_nxt[l] = a_r[l];
    end
    if ($signed(a_r[LN_TAU]) > $signed(lim_w)) begin
      b_nxt[LN_TAU] = lim_w;
    end else if ($signed(a_r[LN_TAU]) < $signed(nlim_w)) begin
      b_nxt[LN_TAU] = nlim_w;
    end
  end

  // Compare against range bounds and offset by the minimum
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      xs_w[l]      = {{(LW-IN_W){b_r[l][IN_W-1]}}, b_r[l]};
      c_lof_nxt[l] = $signed(xs_w[l]) <= $signed(lo_w[l]);
      c_hif_nxt[l] = $signed(xs_w[l]) >= $signed(hi_w[l]);
      num_nxt[l]   = DW'(xs_w[l] - lo_w[l]);
    end
  end

  // Scale by the all-ones code: num * (2^bits - 1)
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      div0_nxt[l] = (NW'(num_r[l]) << lane_bits(l)) - NW'(num_r[l]);
    end
  end

  // One restoring division step per stage, most significant bit first
  always_comb begin
    for (int k = 1; k <= CODE_W; k++) begin
      for (int l = 0; l < LANES; l++) begin
        trial_w[k][l] = NW'(span_w[l]) << (CODE_W - k);
        ge_w[k][l]    = rem_r[k-1][l] >= trial_w[k][l];
        rem_nxt[k][l] = ge_w[k][l] ? (rem_r[k-1][l] - trial_w[k][l]) : rem_r[k-1][l];
        quo_nxt[k][l] = {quo_r[k-1][l][CODE_W-2:0], ge_w[k][l]};
      end
    end
  end

  // Saturate and pack the frame
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (lof_r[CODE_W][l]) begin
        code_w[l] = '0;
      end else if (hif_r[CODE_W][l]) begin
        code_w[l] = lane_full(l);
      end else begin
        code_w[l] = quo_r[CODE_W][l] & lane_full(l);
      end
    end
    frame_nxt = {code_w[LN_POS][POS_BITS-1:0], code_w[LN_VEL][GEN_BITS-1:0],
                 code_w[LN_KP][GEN_BITS-1:0], code_w[LN_KD][GEN_BITS-1:0],
                 code_w[LN_TAU][GEN_BITS-1:0]};
  end

  // Control: config writes, valid bits, output register and skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_range_r <= POS_RANGE_RST;
      vel_range_r <= VEL_RANGE_RST;
      trq_range_r <= TRQ_RANGE_RST;
      trq_limit_r <= TRQ_LIMIT_RST;
      v_r         <= '0;
      out_v_r     <= 1'b0;
      skid_v_r    <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_reg_t'(cfg_ch.index))
          REG_POS_RANGE: pos_range_r <= cfg_ch.data;
          REG_VEL_RANGE: vel_range_r <= cfg_ch.data;
          REG_TRQ_RANGE: trq_range_r <= cfg_ch.data;
          REG_TRQ_LIMIT: trq_limit_r <= cfg_ch.data;
          default: ;
        endcase
      end
      // advance valid bits with the data
      if (en) begin
        v_r <= {v_r[NSTG-2:0], in_ch.valid};
      end
      // hold the output while stalled, park a new request in the skid
      if (out_v_r && !out_ch.ready) begin
        if (push) begin
          skid_v_r <= 1'b1;
        end
      end else if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= push;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        a_r[l]      <= in_vals[l];
        b_r[l]      <= b_nxt[l];
        num_r[l]    <= num_nxt[l];
        rem_r[0][l] <= div0_nxt[l];
        quo_r[0][l] <= '0;
        for (int k = 1; k <= CODE_W; k++) begin
          rem_r[k][l] <= rem_nxt[k][l];
          quo_r[k][l] <= quo_nxt[k][l];
        end
      end
      c_lof_r  <= c_lof_nxt;
      c_hif_r  <= c_hif_nxt;
      lof_r[0] <= c_lof_r;
      hif_r[0] <= c_hif_r;
      for (int k = 1; k <= CODE_W; k++) begin
        lof_r[k] <= lof_r[k-1];
        hif_r[k] <= hif_r[k-1];
      end
    end
    if (out_v_r && !out_ch.ready) begin
      if (push) begin
        skid_frame_r <= frame_nxt;
      end
    end else if (skid_v_r) begin
      out_frame_r <= skid_frame_r;
    end else if (push) begin
      out_frame_r <= frame_nxt;
    end
  end

  // An accepted request always lands in the first stage
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> v_r[ST_IN])
    else $error("accepted request missing from first stage");

  // A frozen pipe keeps its valid bits
  a_freeze_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r))
    else $error("valid bits changed while pipe frozen");

  // The skid fills only behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds a frame while output is empty");

  // An unsaturated position quotient stays below the all-ones code
  a_pos_quo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[LAST] && !lof_r[CODE_W][LN_POS] && !hif_r[CODE_W][LN_POS]
    |-> quo_r[CODE_W][LN_POS] < lane_full(LN_POS))
    else $error("position quotient out of range");

  // An unsaturated torque quotient stays below its 12-bit all-ones code
  a_tau_quo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[LAST] && !lof_r[CODE_W][LN_TAU] && !hif_r[CODE_W][LN_TAU]
    |-> quo_r[CODE_W][LN_TAU] < lane_full(LN_TAU))
    else $error("torque quotient out of range");

endmodule

`default_nettype wire
